// ===== sv/dde_pkg.sv =====
// ----------------------------------------------------------------------------
// dde_pkg
// shared types, constants and arithmetic helpers for the dispersive e update
// ----------------------------------------------------------------------------
`default_nettype none
package dde_pkg;
  localparam int CELLS     = 4096;
  localparam int FRAC_BITS = 20;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int POL_W     = 64 * 3;

  localparam logic [2:0] MED_LORENTZ = 3'd1;
  localparam logic [2:0] MED_PLAIN   = 3'd2;
  localparam logic [2:0] MED_DRUDE   = 3'd3;

  localparam logic [2:0] REG_C1      = 3'd0;
  localparam logic [2:0] REG_C2      = 3'd1;
  localparam logic [2:0] REG_C3      = 3'd2;
  localparam logic [2:0] REG_INPLANE = 3'd3;
  localparam logic [2:0] REG_EPSZ    = 3'd4;
  localparam logic [2:0] REG_PLAIN   = 3'd5;

  typedef struct packed {
    logic [11:0]        cell_index;
    logic [2:0]         med_code;
    logic [5:0][31:0]   flux;
  } item_t;

  typedef struct packed {
    logic [5:0][31:0] field;
    logic             written;
    logic [11:0]      cell_index;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] round_sat(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + (64'sd1 <<< (FRAC_BITS - 1));
    return sat32(y >>> FRAC_BITS);
  endfunction
endpackage
`default_nettype wire

// ===== sv/dde_front.sv =====
// ----------------------------------------------------------------------------
// dde_front
// input queue of two entries; accepts beats and hands them to the back part
// ----------------------------------------------------------------------------
`default_nettype none
module dde_front (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  input  dde_pkg::item_t  in_item,
  output logic            q_valid,
  input  wire             q_ready,
  output dde_pkg::item_t  q_item
);
  import dde_pkg::*;

  item_t     mem [2];
  logic      wptr, rptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (q_valid && q_ready) rptr <= ~rptr;
      count <= count + 2'(in_valid && in_ready) - 2'(q_valid && q_ready);
    end
  end
endmodule
`default_nettype wire

// ===== sv/dde_back.sv =====
// ----------------------------------------------------------------------------
// dde_back
// polarization store read, e computation, recursion update and output stage
// ----------------------------------------------------------------------------
`default_nettype none
module dde_back (
  input  wire               clk,
  input  wire               rst,
  input  wire               q_valid,
  output logic              q_ready,
  input  dde_pkg::item_t    q_item,
  input  wire  [21:0]       c1,
  input  wire  [21:0]       c2,
  input  wire  [30:0]       c3,
  input  wire  [21:0]       inv_inplane,
  input  wire  [21:0]       inv_z,
  input  wire  [21:0]       inv_plain,
  output logic              out_valid,
  input  wire               out_ready,
  output dde_pkg::result_t  out_res
);
  import dde_pkg::*;

  // clearing pass after reset
  logic              clearing;
  logic [IDX_W:0]    clr_cnt;

  logic [POL_W-1:0]  prev_mem  [CELLS];
  logic [POL_W-1:0]  older_mem [CELLS];

  // stage 1: read
  logic             s1_valid;
  item_t            s1_item;
  logic [POL_W-1:0] s1_prev, s1_older;
  // stage 2: e and products
  logic             s2_valid;
  item_t            s2_item;
  logic [5:0][31:0] s2_e;
  logic [5:0][31:0] s2_p;
  logic signed [5:0][63:0] s2_acc;
  // stage 3: output
  logic             s3_valid;

  // bypass for back-to-back items on one cell
  logic [5:0][31:0] s2_pnew;

  logic adv;
  assign adv     = !s3_valid || out_ready;
  assign q_ready = adv && !clearing;
  assign out_valid = s3_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == (IDX_W+1)'(CELLS - 1)) clearing <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) s2_pnew[i] = round_sat(s2_acc[i]);
  end

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [POL_W-1:0] wr_prev, wr_older;
  always_comb begin
    wr_en    = clearing || (adv && s2_valid && s2_item.med_code == MED_DRUDE);
    wr_addr  = clearing ? clr_cnt[IDX_W-1:0] : s2_item.cell_index[IDX_W-1:0];
    wr_prev  = clearing ? '0 : s2_pnew;
    wr_older = clearing ? '0 : s2_p;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[wr_addr]  <= wr_prev;
      older_mem[wr_addr] <= wr_older;
    end
  end

  logic [POL_W-1:0] rd_prev, rd_older;
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_prev  <= prev_mem[q_item.cell_index[IDX_W-1:0]];
      rd_older <= older_mem[q_item.cell_index[IDX_W-1:0]];
    end
  end

  // forwarding: state written in the same cycle as the read
  logic fwd_s1;
  always_ff @(posedge clk) begin
    if (adv) fwd_s1 <= wr_en && !clearing &&
                       wr_addr == q_item.cell_index[IDX_W-1:0];
  end
  logic [POL_W-1:0] fwd_prev, fwd_older;
  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_prev  <= wr_prev;
      fwd_older <= wr_older;
    end
  end
  logic s1_hit2;
  always_comb begin
    s1_prev  = fwd_s1 ? fwd_prev  : rd_prev;
    s1_older = fwd_s1 ? fwd_older : rd_older;
    s1_hit2  = s2_valid && s2_item.med_code == MED_DRUDE &&
               s2_item.cell_index == s1_item.cell_index;
    if (s1_hit2) begin
      s1_prev  = s2_pnew;
      s1_older = s2_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= q_valid && q_ready;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= q_item;
      s2_item <= s1_item;
      for (int i = 0; i < 6; i++) begin
        logic signed [31:0] p, o, ek;
        logic [21:0]        inv1;
        p  = s1_prev[i*32 +: 32];
        o  = s1_older[i*32 +: 32];
        ek = sat32(64'(signed'(s1_item.flux[i])) - 64'(p));
        inv1 = (i >= 4) ? inv_z : inv_inplane;
        s2_p[i] <= p;
        case (s1_item.med_code)
          MED_LORENTZ: begin
            s2_e[i]   <= ek;
            s2_acc[i] <= 64'(ek) * $signed({1'b0, inv1});
          end
          MED_PLAIN: begin
            s2_e[i]   <= s1_item.flux[i];
            s2_acc[i] <= 64'(signed'(s1_item.flux[i])) * $signed({1'b0, inv_plain});
          end
          default: begin
            s2_e[i]   <= ek;
            s2_acc[i] <= 64'(p) * $signed({1'b0, c1}) - 64'(o) * $signed({1'b0, c2})
                         + 64'(ek) * $signed({1'b0, c3});
          end
        endcase
      end
      out_res.cell_index <= s2_item.cell_index;
      case (s2_item.med_code)
        MED_LORENTZ, MED_PLAIN: begin
          out_res.written <= 1'b1;
          out_res.field   <= s2_pnew;
        end
        MED_DRUDE: begin
          out_res.written <= 1'b1;
          out_res.field   <= s2_e;
        end
        default: begin
          out_res.written <= 1'b0;
          out_res.field   <= '0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sv/drude_dispersive_e_update.sv =====
// ----------------------------------------------------------------------------
// drude_dispersive_e_update
// electric field update of one fdtd cell per beat with drude polarization
// ----------------------------------------------------------------------------
// usage: each s_axis beat carries a cell index, medium code and complex flux
// density d; each m_axis beat returns field e, a written flag and the index.
// one beat is taken per cycle while the pipeline is not stalled or clearing;
// a beat from the input queue passes the store read, multiply and output
// stages. registers are written through cfg_we/cfg_addr/cfg_data only while
// idle; the user must keep to this, the block does not enforce it. after
// reset a clearing pass over all 4096 cells zeroes the polarization store;
// during it only the two-entry input queue takes beats. a stall on
// m_axis_tready holds the pipeline; the input queue takes beats until full.
// ----------------------------------------------------------------------------
`default_nettype none
module drude_dispersive_e_update (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_index[11:0], medium_req[14:12], flux_x_re, flux_x_im, flux_y_re,
  // flux_y_im, flux_z_re, flux_z_im (32 each from bit 15), zero pad to 208
  input  wire  [207:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // field_x_re, field_x_im, field_y_re, field_y_im, field_z_re, field_z_im,
  // field_written[192], out_cell_index[204:193], zero pad to 208
  output logic [207:0] m_axis_tdata,
  input  wire          cfg_we,
  input  wire  [2:0]   cfg_addr,
  input  wire  [30:0]  cfg_data
);
  import dde_pkg::*;

  logic [21:0] c1, c2, inv_inplane, inv_z, inv_plain;
  logic [30:0] c3;
  item_t   in_item, q_item;
  logic    q_valid, q_ready;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= 22'd2097152; c2 <= 22'd1048576; c3 <= 31'd0;
      inv_inplane <= 22'd215313; inv_z <= 22'd355449; inv_plain <= 22'd1048576;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_C1:      c1 <= cfg_data[21:0];
        REG_C2:      c2 <= cfg_data[21:0];
        REG_C3:      c3 <= cfg_data;
        REG_INPLANE: inv_inplane <= cfg_data[21:0];
        REG_EPSZ:    inv_z <= cfg_data[21:0];
        REG_PLAIN:   inv_plain <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_item.cell_index = s_axis_tdata[11:0];
    in_item.med_code   = s_axis_tdata[14:12];
    for (int i = 0; i < 6; i++) in_item.flux[i] = s_axis_tdata[15 + i*32 +: 32];
  end

  dde_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  dde_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .c1(c1), .c2(c2), .c3(c3),
    .inv_inplane(inv_inplane), .inv_z(inv_z), .inv_plain(inv_plain),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < 6; i++) m_axis_tdata[i*32 +: 32] = res.field[i];
    m_axis_tdata[192]     = res.written;
    m_axis_tdata[204:193] = res.cell_index;
  end
endmodule
`default_nettype wire

// ===== sim/drude_dispersive_e_update_tb.sv =====
// ----------------------------------------------------------------------------
// drude_dispersive_e_update_tb
// self-checking bench for the dispersive e field update: directed and random
// cells over all medium codes, register settings changed between phases,
// random idling on both sides, results checked against a local predictor
// ----------------------------------------------------------------------------
`default_nettype none

class field_scoreboard;
  logic signed [31:0] prev_pol [4096][3][2];
  logic signed [31:0] older_pol [4096][3][2];
  logic [63:0] c1, c2, c3, inplane, epsz, plain;
  logic [207:0] pending_fields[$];
  int errors;
  int checked;

  function void clear_state();
    for (int c = 0; c < 4096; c++)
      for (int a = 0; a < 3; a++)
        for (int k = 0; k < 2; k++) begin
          prev_pol[c][a][k] = 0;
          older_pol[c][a][k] = 0;
        end
    c1 = 2097152; c2 = 1048576; c3 = 0;
    inplane = 215313; epsz = 355449; plain = 1048576;
    errors = 0;
    checked = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [30:0] val);
    case (idx)
      dde_pkg::REG_C1:      c1 = 64'(val[21:0]);
      dde_pkg::REG_C2:      c2 = 64'(val[21:0]);
      dde_pkg::REG_C3:      c3 = 64'(val[30:0]);
      dde_pkg::REG_INPLANE: inplane = 64'(val[21:0]);
      dde_pkg::REG_EPSZ:    epsz = 64'(val[21:0]);
      dde_pkg::REG_PLAIN:   plain = 64'(val[21:0]);
      default: ;
    endcase
  endfunction

  function logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function logic signed [63:0] round_clamp(logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + 64'sd524288;
    return clamp32(y >>> 20);
  endfunction

  // works out e for one accepted beat and advances the polarization store for drude beats
  function void note_input(logic [207:0] beat);
    logic [11:0] cell_id;
    logic [2:0] med;
    logic [207:0] res;
    logic signed [63:0] d, p, o, e, acc, w;
    cell_id = beat[11:0];
    med = beat[14:12];
    res = '0;
    if (med == dde_pkg::MED_LORENTZ || med == dde_pkg::MED_PLAIN ||
        med == dde_pkg::MED_DRUDE) begin
      for (int a = 0; a < 3; a++)
        for (int k = 0; k < 2; k++) begin
          d = $signed(beat[15 + 32 * (2 * a + k) +: 32]);
          p = prev_pol[cell_id][a][k];
          o = older_pol[cell_id][a][k];
          w = (a == 2) ? $signed(epsz) : $signed(inplane);
          if (med == dde_pkg::MED_LORENTZ)
            e = round_clamp(clamp32(d - p) * w);
          else if (med == dde_pkg::MED_PLAIN)
            e = round_clamp(d * $signed(plain));
          else begin
            e = clamp32(d - p);
            acc = $signed(c1) * p - $signed(c2) * o + $signed(c3) * e;
            acc = round_clamp(acc);
            older_pol[cell_id][a][k] = p[31:0];
            prev_pol[cell_id][a][k] = acc[31:0];
          end
          res[32 * (2 * a + k) +: 32] = e[31:0];
        end
      res[192] = 1'b1;
    end
    res[204:193] = cell_id;
    pending_fields.push_back(res);
  endfunction

  task report(string msg);
    errors++;
    $display("%s", msg);
  endtask

  task check_result(logic [207:0] got);
    logic [207:0] exp_r;
    checked++;
    if (pending_fields.size() == 0) begin
      report($sformatf("unexpected result beat: %h", got));
      return;
    end
    exp_r = pending_fields.pop_front();
    for (int f = 0; f < 6; f++)
      if (got[32 * f +: 32] !== exp_r[32 * f +: 32])
        report($sformatf("cell %0d field %0d: got %h want %h", exp_r[204:193], f,
                         got[32 * f +: 32], exp_r[32 * f +: 32]));
    if (got[192] !== exp_r[192])
      report($sformatf("cell %0d written flag: got %b want %b", exp_r[204:193],
                       got[192], exp_r[192]));
    if (got[204:193] !== exp_r[204:193])
      report($sformatf("cell index: got %0d want %0d", got[204:193], exp_r[204:193]));
  endtask
endclass

module drude_dispersive_e_update_tb;
  import dde_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [207:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [207:0] m_axis_tdata;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [30:0] cfg_data;

  field_scoreboard sb;
  bit calm;
  int idle_cycles;
  int beats_in;
  int drude_beats;
  int hot_cells[8];

  drude_dispersive_e_update u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // result side: check accepted beats, random stalls in bursts
  initial begin
    int burst;
    burst = 0;
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (burst > 0) burst--;
      else if (!calm && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 7);
      m_axis_tready <= (burst == 0);
    end
  end

  // watchdog on cycles with no beat moving either way
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [11:0] cell_id, input logic [2:0] med,
                           input logic [5:0][31:0] flux);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tdata <= {1'b0, flux, med, cell_id};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_input({1'b0, flux, med, cell_id});
    beats_in++;
    if (med == MED_DRUDE) drude_beats++;
    // valid stays high for the next call; lowered by an idle burst or a drain
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_fields.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] flux_value(input int mode);
    case (mode)
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom();
      default: return $signed($urandom_range(0, 8 << 20)) - (4 << 20);
    endcase
  endfunction

  function automatic logic [5:0][31:0] rand_flux(input bit wild);
    logic [5:0][31:0] f;
    for (int i = 0; i < 6; i++)
      f[i] = wild ? flux_value($urandom_range(0, 4)) : flux_value(4);
    return f;
  endfunction

  task automatic random_phase(input int n);
    logic [2:0] med;
    logic [11:0] cell_id;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    med = MED_LORENTZ;
        2, 3:    med = MED_PLAIN;
        4, 5, 6: med = MED_DRUDE;
        default: med = 3'($urandom_range(0, 7));
      endcase
      if ($urandom_range(0, 2) != 0) cell_id = 12'(hot_cells[$urandom_range(0, 7)]);
      else cell_id = 12'($urandom());
      send_beat(cell_id, med, rand_flux($urandom_range(0, 4) == 0));
    end
  endtask

  initial begin
    logic [5:0][31:0] f;
    sb = new();
    sb.clear_state();
    calm = 0;
    beats_in = 0;
    drude_beats = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_data = '0;
    for (int i = 0; i < 8; i++) hot_cells[i] = $urandom_range(0, 4095);
    hot_cells[0] = 0;
    hot_cells[1] = 4095;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: extremes under reset values, every medium code
    for (int m = 0; m < 8; m++) begin
      for (int i = 0; i < 6; i++) f[i] = flux_value(m % 3);
      send_beat(12'd0, m[2:0], f);
    end
    f = {6{32'h7fffffff}};
    send_beat(12'd4095, MED_DRUDE, f);
    send_beat(12'd4095, MED_LORENTZ, f);
    f = {6{32'h80000000}};
    send_beat(12'd4095, MED_DRUDE, f);
    send_beat(12'd4095, MED_LORENTZ, f);
    drain();

    // drude with drive and maximal weights, then medium 1 reading the store
    write_reg(REG_C3, 31'h7fffffff);
    write_reg(REG_C1, 31'h3fffff);
    write_reg(REG_C2, 31'h0);
    write_reg(3'd6, 31'h1234);
    write_reg(3'd7, 31'h7fffffff);
    for (int i = 0; i < 3; i++) send_beat(12'd7, MED_DRUDE, rand_flux(1));
    send_beat(12'd7, MED_LORENTZ, rand_flux(1));
    send_beat(12'd7, MED_PLAIN, rand_flux(1));
    drain();

    // random phases under different register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_C1, (ph == 0) ? 31'h0 : (ph == 1) ? 31'h3fffff : $urandom_range(0, 3 << 20));
      write_reg(REG_C2, (ph == 1) ? 31'h3fffff : $urandom_range(0, 2 << 20));
      write_reg(REG_C3, (ph == 2) ? 31'h0 : (ph == 3) ? 31'h7fffffff
                         : $urandom_range(0, 1 << 22));
      write_reg(REG_INPLANE, (ph == 0) ? 31'h0 : (ph == 1) ? 31'h7fffffff : $urandom());
      write_reg(REG_EPSZ, (ph == 0) ? 31'h3fffff : $urandom());
      write_reg(REG_PLAIN, (ph == 2) ? 31'h3fffff : (ph == 3) ? 31'h0 : $urandom());
      if (ph == 5) calm = 1;
      random_phase(280);
      drain();
    end

    $display("%0d cell beats sent, %0d drude updates, %0d results checked",
             beats_in, drude_beats, sb.checked);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

`default_nettype wire

// ===== drude_dispersive_e_update.f =====
sv/dde_pkg.sv
sv/dde_front.sv
sv/dde_back.sv
sv/drude_dispersive_e_update.sv
sim/drude_dispersive_e_update_tb.sv
